// ===== rtl/core/md2_hash_engine_defines.svh =====
// assertion macros shared by the md2 hash engine rtl
// no dependencies; expects clk and arst_n in the scope where a macro is used
`ifndef MD2_HASH_ENGINE_DEFINES_SVH
`define MD2_HASH_ENGINE_DEFINES_SVH

// clocked property, disabled while reset is asserted
`define MD2_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression that must never hold at a clock edge
`define MD2_ASSERT_NEVER(lbl, expr, msg) \
	`MD2_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/core/md2_pkg.sv =====
// shared types, constants and the md2 s-box table
// no dependencies
package md2_pkg;

	localparam int BlkBytes  = 16;
	localparam int WorkBytes = 3 * BlkBytes;
	localparam int Rounds    = 18;

	typedef logic [7:0] byte_t;

	typedef enum logic {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} opcode_t;

	typedef enum logic {
		STEP_MIX = 1'b0,
		STEP_SUM = 1'b1
	} step_mode_t;

	localparam byte_t SBOX [256] = '{
		8'd41, 8'd46, 8'd67, 8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
		8'd61, 8'd54, 8'd84, 8'd161, 8'd236, 8'd240, 8'd6, 8'd19,
		8'd98, 8'd167, 8'd5, 8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
		8'd152, 8'd147, 8'd43, 8'd217, 8'd188, 8'd76, 8'd130, 8'd202,
		8'd30, 8'd155, 8'd87, 8'd60, 8'd253, 8'd212, 8'd224, 8'd22,
		8'd103, 8'd66, 8'd111, 8'd24, 8'd138, 8'd23, 8'd229, 8'd18,
		8'd190, 8'd78, 8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
		8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47, 8'd238, 8'd122,
		8'd169, 8'd104, 8'd121, 8'd145, 8'd21, 8'd178, 8'd7, 8'd63,
		8'd148, 8'd194, 8'd16, 8'd137, 8'd11, 8'd34, 8'd95, 8'd33,
		8'd128, 8'd127, 8'd93, 8'd154, 8'd90, 8'd144, 8'd50, 8'd39,
		8'd53, 8'd62, 8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
		8'd255, 8'd25, 8'd48, 8'd179, 8'd72, 8'd165, 8'd181, 8'd209,
		8'd215, 8'd94, 8'd146, 8'd42, 8'd172, 8'd86, 8'd170, 8'd198,
		8'd79, 8'd184, 8'd56, 8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
		8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4, 8'd241,
		8'd69, 8'd157, 8'd112, 8'd89, 8'd100, 8'd113, 8'd135, 8'd32,
		8'd134, 8'd91, 8'd207, 8'd101, 8'd230, 8'd45, 8'd168, 8'd2,
		8'd27, 8'd96, 8'd37, 8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
		8'd28, 8'd70, 8'd97, 8'd105, 8'd52, 8'd64, 8'd126, 8'd15,
		8'd85, 8'd71, 8'd163, 8'd35, 8'd221, 8'd81, 8'd175, 8'd58,
		8'd195, 8'd92, 8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
		8'd44, 8'd83, 8'd13, 8'd110, 8'd133, 8'd40, 8'd132, 8'd9,
		8'd211, 8'd223, 8'd205, 8'd244, 8'd65, 8'd129, 8'd77, 8'd82,
		8'd106, 8'd220, 8'd55, 8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
		8'd36, 8'd225, 8'd123, 8'd8, 8'd12, 8'd189, 8'd177, 8'd74,
		8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99, 8'd232, 8'd109,
		8'd233, 8'd203, 8'd213, 8'd254, 8'd59, 8'd0, 8'd29, 8'd57,
		8'd242, 8'd239, 8'd183, 8'd14, 8'd102, 8'd88, 8'd208, 8'd228,
		8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75, 8'd10,
		8'd49, 8'd68, 8'd80, 8'd180, 8'd143, 8'd237, 8'd31, 8'd26,
		8'd219, 8'd153, 8'd141, 8'd51, 8'd159, 8'd17, 8'd131, 8'd20
	};

endpackage

// ===== rtl/core/md2_stream_if.sv =====
// valid/ready channel interfaces for the md2 hash engine
// message items in, digest bytes out; no dependencies
interface md2_msg_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] message_byte;

	modport source (output valid, output opcode, output message_byte, input ready);
	modport sink (input valid, input opcode, input message_byte, output ready);
endinterface

interface md2_digest_if;
	logic       valid;
	logic       ready;
	logic [7:0] digest_byte;
	logic [3:0] byte_index;
	logic       last_byte;

	modport source (output valid, output digest_byte, output byte_index, output last_byte,
		input ready);
	modport sink (input valid, input digest_byte, input byte_index, input last_byte,
		output ready);
endinterface

// ===== rtl/core/md2_step_unit.sv =====
// shared s-box step: one table lookup and xor per cycle
// used for both the 48-byte mixing rounds and the checksum update; uses md2_pkg
module md2_step_unit (
	input  md2_pkg::step_mode_t mode,
	input  md2_pkg::byte_t      head,
	input  md2_pkg::byte_t      blk_byte,
	input  md2_pkg::byte_t      acc,
	output md2_pkg::byte_t      result
);
	import md2_pkg::*;

	byte_t sbox_idx;

	always_comb begin
		case (mode)
			STEP_MIX: sbox_idx = acc;
			STEP_SUM: sbox_idx = blk_byte ^ acc;
			default:  sbox_idx = acc;
		endcase
	end

	assign result = head ^ SBOX[sbox_idx];

endmodule

// ===== rtl/core/md2_hash_engine.sv =====
// md2 message digest engine: block buffer, state, checksum and sequencer
// uses md2_pkg, md2_stream_if, md2_step_unit and md2_hash_engine_defines.svh
//
// usage:
//   msg carries one item per transfer: opcode absorb appends message_byte to
//   the 16-byte block, opcode finish pads, closes the message and produces the
//   digest. digest carries the 16 digest bytes in order, byte_index 0 first,
//   last_byte high on byte 15.
// sequence:
//   an absorb that does not complete a block only stores its byte and leaves
//   msg.ready high. the absorb that completes a block runs a load state, then
//   18 rounds x 48 steps of the single s-box step unit, then 16 checksum steps
//   on the same unit, before msg.ready returns. a finish runs the block compress
//   and checksum, then one more compress over the checksum, after which the 16
//   digest bytes are offered, at most one per cycle.
// msg.ready is low during block work and after a finish until the last digest
// transfer. a stalled digest receiver simply holds the engine in its output
// phase with the current byte steady. after the last digest byte the state,
// checksum and fill count return to zero and the next item opens a new
// message. arst_n clears the same state asynchronously.
`include "md2_hash_engine_defines.svh"

module md2_hash_engine (
	input logic          clk,
	input logic          arst_n,
	md2_msg_if.sink      msg,
	md2_digest_if.source digest
);
	import md2_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_MIX  = 5'b00100,
		ST_SUM  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t     state_q;
	logic [5:0] step_q;
	logic [4:0] round_q;
	logic [3:0] fill_q;
	logic       fin_q;
	logic       second_q;
	byte_t      acc_q;

	byte_t work_q  [WorkBytes];
	byte_t chain_q [BlkBytes];
	byte_t csum_q  [BlkBytes];
	byte_t blk_q   [BlkBytes];

	byte_t      padded   [BlkBytes];
	byte_t      load_blk [BlkBytes];
	byte_t      pad_val;
	byte_t      step_new;
	byte_t      step_head;
	step_mode_t step_mode;
	logic       in_fire;
	logic       out_fire;
	logic       mix_last_step;
	logic       mix_done;
	logic       emit_last;

	assign in_fire       = msg.valid & msg.ready;
	assign out_fire      = digest.valid & digest.ready;
	assign mix_last_step = (step_q == 6'(WorkBytes - 1));
	assign mix_done      = mix_last_step && (round_q == 5'(Rounds - 1));
	assign emit_last     = (step_q[3:0] == 4'hF);

	assign msg.ready = (state_q == ST_IDLE);

	assign digest.valid       = (state_q == ST_EMIT);
	assign digest.digest_byte = chain_q[step_q[3:0]];
	assign digest.byte_index  = step_q[3:0];
	assign digest.last_byte   = emit_last;

	// n missing bytes each take the value n
	assign pad_val = 8'(5'd16 - {1'b0, fill_q});

	always_comb begin
		for (int k = 0; k < BlkBytes; k++) begin
			padded[k]   = (4'(k) >= fill_q) ? pad_val : blk_q[k];
			load_blk[k] = second_q ? csum_q[k] : blk_q[k];
		end
	end

	assign step_mode = (state_q == ST_SUM) ? STEP_SUM : STEP_MIX;
	assign step_head = (state_q == ST_SUM) ? csum_q[0] : work_q[0];

	md2_step_unit u_step (
		.mode     (step_mode),
		.head     (step_head),
		.blk_byte (blk_q[step_q[3:0]]),
		.acc      (acc_q),
		.result   (step_new)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			round_q  <= '0;
			fill_q   <= '0;
			fin_q    <= 1'b0;
			second_q <= 1'b0;
			acc_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (msg.opcode == OP_FINISH) begin
							fin_q   <= 1'b1;
							state_q <= ST_LOAD;
						end else if (fill_q == 4'hF) begin
							fill_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							fill_q <= fill_q + 4'd1;
						end
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					round_q <= '0;
					acc_q   <= '0;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					if (mix_last_step) begin
						step_q <= '0;
						if (mix_done) begin
							if (second_q) begin
								state_q <= ST_EMIT;
							end else begin
								// checksum chain starts from its last byte
								acc_q   <= csum_q[BlkBytes - 1];
								state_q <= ST_SUM;
							end
						end else begin
							acc_q   <= step_new + 8'(round_q);
							round_q <= round_q + 5'd1;
						end
					end else begin
						step_q <= step_q + 6'd1;
						acc_q  <= step_new;
					end
				end
				ST_SUM: begin
					acc_q <= step_new;
					if (step_q[3:0] == 4'hF) begin
						step_q <= '0;
						if (fin_q) begin
							second_q <= 1'b1;
							state_q  <= ST_LOAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				ST_EMIT: begin
					if (out_fire) begin
						if (emit_last) begin
							step_q   <= '0;
							fill_q   <= '0;
							fin_q    <= 1'b0;
							second_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							step_q <= step_q + 6'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// chain state and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BlkBytes; k++) begin
				chain_q[k] <= '0;
				csum_q[k]  <= '0;
			end
		end else begin
			if (state_q == ST_MIX && mix_done) begin
				// work array is one rotation short of home on the last step
				for (int k = 0; k < BlkBytes; k++) begin
					chain_q[k] <= work_q[k + 1];
				end
			end
			if (state_q == ST_SUM) begin
				for (int k = 0; k < BlkBytes - 1; k++) begin
					csum_q[k] <= csum_q[k + 1];
				end
				csum_q[BlkBytes - 1] <= step_new;
			end
			if (out_fire && emit_last) begin
				for (int k = 0; k < BlkBytes; k++) begin
					chain_q[k] <= '0;
					csum_q[k]  <= '0;
				end
			end
		end
	end

	// 48-byte work array rotates one byte per step through the step unit
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			for (int k = 0; k < BlkBytes; k++) begin
				work_q[k]                <= chain_q[k];
				work_q[BlkBytes + k]     <= load_blk[k];
				work_q[2 * BlkBytes + k] <= chain_q[k] ^ load_blk[k];
			end
		end else if (state_q == ST_MIX) begin
			for (int k = 0; k < WorkBytes - 1; k++) begin
				work_q[k] <= work_q[k + 1];
			end
			work_q[WorkBytes - 1] <= step_new;
		end
	end

	// block buffer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (msg.opcode == OP_FINISH) begin
				for (int k = 0; k < BlkBytes; k++) begin
					blk_q[k] <= padded[k];
				end
			end else begin
				blk_q[fill_q] <= msg.message_byte;
			end
		end
	end

	`MD2_ASSERT(a_emit_only_after_finish, digest.valid |-> fin_q && second_q,
		"digest offered outside the finish sequence")
	`MD2_ASSERT(a_mix_counters, state_q == ST_MIX |-> step_q < 6'd48 && round_q < 5'd18,
		"mixing counters out of range")
	`MD2_ASSERT_NEVER(a_sum_step_range, state_q == ST_SUM && step_q > 6'd15,
		"checksum step beyond block length")
	`MD2_ASSERT(a_full_block_compress,
		in_fire && msg.opcode == OP_ABSORB && fill_q == 4'hF
			|=> state_q == ST_LOAD && fill_q == 4'h0,
		"full block did not start compression")
	`MD2_ASSERT(a_clear_after_digest,
		out_fire && digest.last_byte
			|=> state_q == ST_IDLE && !fin_q && fill_q == 4'h0 && chain_q[0] == 8'h0,
		"state not cleared after last digest byte")

endmodule

// ===== test/md2_digest_checker.sv =====
`timescale 1ns / 100ps
// digest checker for md2_hash_engine: watches both channels, keeps its own md2 state
// and compares every digest transfer with the predicted bytes; uses md2_pkg, md2_stream_if
module md2_digest_checker (
	input  logic   clk,
	input  logic   arst_n,
	md2_msg_if     msg,
	md2_digest_if  digest,
	output int     fail_count,
	output int     pending
);
	import md2_pkg::*;

	typedef struct packed {
		byte_t      data;
		logic [3:0] idx;
		logic       last;
	} digest_rec_t;

	digest_rec_t digest_q[$];

	byte_t      chain_st [BlkBytes];
	byte_t      sum_st [BlkBytes];
	byte_t      blk_buf [BlkBytes];
	logic [4:0] fill_cnt;

	function automatic void md2_compress(input byte_t blk [BlkBytes], input bit fold_sum);
		byte_t w [WorkBytes];
		byte_t t;
		for (int k = 0; k < BlkBytes; k++) begin
			w[k]                = chain_st[k];
			w[BlkBytes + k]     = blk[k];
			w[2 * BlkBytes + k] = chain_st[k] ^ blk[k];
		end
		t = '0;
		for (int r = 0; r < Rounds; r++) begin
			for (int k = 0; k < WorkBytes; k++) begin
				w[k] = w[k] ^ SBOX[t];
				t    = w[k];
			end
			t = t + 8'(r);
		end
		for (int k = 0; k < BlkBytes; k++)
			chain_st[k] = w[k];
		if (fold_sum) begin
			t = sum_st[BlkBytes - 1];
			for (int k = 0; k < BlkBytes; k++) begin
				sum_st[k] = sum_st[k] ^ SBOX[blk[k] ^ t];
				t         = sum_st[k];
			end
		end
	endfunction

	function automatic void clear_state();
		for (int k = 0; k < BlkBytes; k++) begin
			chain_st[k] = '0;
			sum_st[k]   = '0;
			blk_buf[k]  = '0;
		end
		fill_cnt = '0;
	endfunction

	function automatic void predict_item(input opcode_t op, input byte_t b);
		byte_t sum_copy [BlkBytes];
		if (op == OP_ABSORB) begin
			blk_buf[fill_cnt[3:0]] = b;
			fill_cnt = fill_cnt + 5'd1;
			if (fill_cnt == 5'(BlkBytes)) begin
				md2_compress(blk_buf, 1'b1);
				fill_cnt = '0;
			end
		end else begin
			// pad with the count of missing bytes, a full block when empty
			for (int k = int'(fill_cnt); k < BlkBytes; k++)
				blk_buf[k] = 8'(BlkBytes - int'(fill_cnt));
			md2_compress(blk_buf, 1'b1);
			sum_copy = sum_st;
			md2_compress(sum_copy, 1'b0);
			for (int k = 0; k < BlkBytes; k++)
				digest_q.push_back('{data: chain_st[k], idx: 4'(k), last: (k == BlkBytes - 1)});
			clear_state();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		digest_rec_t want;
		if (!arst_n) begin
			clear_state();
			digest_q.delete();
			fail_count = 0;
		end else begin
			if (digest.valid && digest.ready) begin
				if (digest_q.size() == 0) begin
					fail_count++;
					$display("%0t: digest transfer with nothing expected: byte %02h index %0d last %0b",
						$time, digest.digest_byte, digest.byte_index, digest.last_byte);
				end else begin
					want = digest_q.pop_front();
					if (digest.digest_byte !== want.data) begin
						fail_count++;
						$display("%0t: digest_byte expected %02h got %02h",
							$time, want.data, digest.digest_byte);
					end
					if (digest.byte_index !== want.idx) begin
						fail_count++;
						$display("%0t: byte_index expected %0d got %0d",
							$time, want.idx, digest.byte_index);
					end
					if (digest.last_byte !== want.last) begin
						fail_count++;
						$display("%0t: last_byte expected %0b got %0b",
							$time, want.last, digest.last_byte);
					end
				end
			end
			if (msg.valid && msg.ready)
				predict_item(opcode_t'(msg.opcode), msg.message_byte);
		end
		pending = digest_q.size();
	end

endmodule

// ===== test/tb_md2_hash_engine.sv =====
`timescale 1ns / 100ps
// testbench top for md2_hash_engine: clock, reset, message stimulus and verdict
// uses md2_pkg, md2_stream_if and md2_digest_checker
module tb_md2_hash_engine;
	import md2_pkg::*;

	localparam int NumItems  = 280;
	localparam int StallLimit = 10000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   items_sent;
	int   stall_cycles;
	bit   quiet_phase;

	md2_msg_if    msg_ch ();
	md2_digest_if digest_ch ();

	md2_hash_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (digest_ch)
	);

	md2_digest_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg_ch),
		.digest     (digest_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// a stretch of items with no idling on either side
	assign quiet_phase = (items_sent >= 130) && (items_sent < 190);

	initial begin
		digest_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			digest_ch.ready = quiet_phase || ($urandom_range(99) >= 23);
		end
	end

	always @(posedge clk) begin
		if ((msg_ch.valid && msg_ch.ready) || (digest_ch.valid && digest_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_item(input opcode_t op, input byte_t b);
		while (!quiet_phase && $urandom_range(99) < 23) begin
			msg_ch.valid = 1'b0;
			@(negedge clk);
		end
		msg_ch.valid        = 1'b1;
		msg_ch.opcode       = op;
		msg_ch.message_byte = b;
		@(posedge clk);
		while (!msg_ch.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		for (int k = 0; k < len; k++)
			send_item(OP_ABSORB, byte_t'($urandom_range(255)));
		send_item(OP_FINISH, byte_t'($urandom_range(255)));
	endtask

	initial begin
		int len;
		stall_cycles        = 0;
		items_sent          = 0;
		msg_ch.valid        = 1'b0;
		msg_ch.opcode       = OP_ABSORB;
		msg_ch.message_byte = '0;
		arst_n              = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty message, the byte on a finish has to be ignored
		send_item(OP_FINISH, 8'hff);
		// short message with the byte extremes
		send_item(OP_ABSORB, 8'h00);
		send_item(OP_ABSORB, 8'hff);
		send_item(OP_FINISH, 8'h00);
		// exactly one block, so the finish pads a whole block
		for (int k = 0; k < BlkBytes; k++)
			send_item(OP_ABSORB, byte_t'(k * 17));
		send_item(OP_FINISH, 8'ha5);

		while (items_sent < NumItems) begin
			case ($urandom_range(9))
				0: len = 0;
				1: len = 15;
				2: len = 16;
				3: len = 17;
				4: len = 32;
				default: len = $urandom_range(1, 40);
			endcase
			send_message(len);
		end
		msg_ch.valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
